[rtl/mpba_pkg.sv]
// Types, codes and helper functions shared by the multi-pool block allocator.
// Used by mpba_regs, mpba_ctrl, mpba_dp and multi_pool_block_allocator_top.
package mpba_pkg;

	// Fixed field widths of the interface
	localparam int unsigned SIZE_W  = 16;
	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned REG_W   = 64;
	localparam int unsigned PADDR_W = 6;
	localparam int unsigned MAP_W   = 64;

	// Request codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ZERO_SIZE = 3'd1,
		ST_TOO_LARGE = 3'd2,
		ST_NO_BLOCK  = 3'd3,
		ST_BAD_ADDR  = 3'd4,
		ST_NOT_USED  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		REG_SIZES     = 3'd0,
		REG_COUNTS    = 3'd1,
		REG_STARTS_LO = 3'd2,
		REG_STARTS_HI = 3'd3,
		REG_ALLOW     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic              allow_larger;
		logic [REG_W-1:0]  starts_high;
		logic [REG_W-1:0]  starts_low;
		logic [REG_W-1:0]  counts;
		logic [REG_W-1:0]  sizes;
	} cfg_t;

	typedef enum logic [2:0] {
		S_IDLE       = 3'd0,
		S_START      = 3'd1,
		S_ALLOC_SCAN = 3'd2,
		S_FREE_SCAN  = 3'd3,
		S_DIV        = 3'd4,
		S_FREE_UPD   = 3'd5,
		S_FINISH     = 3'd6
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic    load_in;
		logic    pool_inc;
		logic    mark_found;
		logic    claim;
		logic    div_init;
		logic    div_step;
		logic    clr_bit;
		logic    st_we;
		status_t st_code;
		logic    out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic is_free;
		logic zero_req;
		logic zero_addr;
		logic allow_larger;
		logic elig;
		logic has_free;
		logic found;
		logic match;
		logic last_pool;
		logic div_last;
		logic bit_set;
		logic out_free;
	} dp_stat_t;

	// Lowest set bit of a 64-bit vector: {found, index}, as an 8 x 8 two-level search
	function automatic logic [6:0] find_first(input logic [MAP_W-1:0] v);
		logic [7:0] grp;
		logic [7:0] sel;
		logic [2:0] g;
		logic [2:0] b;
		g = 3'd0;
		b = 3'd0;
		for (int i = 0; i < 8; i++) begin
			grp[i] = |v[8*i +: 8];
		end
		for (int i = 7; i >= 0; i--) begin
			if (grp[i]) begin
				g = 3'(i);
			end
		end
		sel = v[{g, 3'b000} +: 8];
		for (int i = 7; i >= 0; i--) begin
			if (sel[i]) begin
				b = 3'(i);
			end
		end
		return {|grp, g, b};
	endfunction

endpackage

[rtl/mpba_regs.sv]
// APB-style configuration registers of the multi-pool block allocator.
// Depends on mpba_pkg for the register map and the cfg_t bundle.
module mpba_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mpba_pkg::PADDR_W-1:0]  paddr,
	input  logic [mpba_pkg::REG_W-1:0]    pwdata,
	output logic [mpba_pkg::REG_W-1:0]    prdata,
	output logic                          pready,
	output mpba_pkg::cfg_t                cfg
);

	mpba_pkg::cfg_t     cfg_q;
	mpba_pkg::reg_idx_t idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign idx    = mpba_pkg::reg_idx_t'(paddr[mpba_pkg::PADDR_W-1:3]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// Write the addressed register; drop writes beyond the map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				mpba_pkg::REG_SIZES:     cfg_q.sizes        <= pwdata;
				mpba_pkg::REG_COUNTS:    cfg_q.counts       <= pwdata;
				mpba_pkg::REG_STARTS_LO: cfg_q.starts_low   <= pwdata;
				mpba_pkg::REG_STARTS_HI: cfg_q.starts_high  <= pwdata;
				mpba_pkg::REG_ALLOW:     cfg_q.allow_larger <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			mpba_pkg::REG_SIZES:     prdata = cfg_q.sizes;
			mpba_pkg::REG_COUNTS:    prdata = cfg_q.counts;
			mpba_pkg::REG_STARTS_LO: prdata = cfg_q.starts_low;
			mpba_pkg::REG_STARTS_HI: prdata = cfg_q.starts_high;
			mpba_pkg::REG_ALLOW:     prdata = {{(mpba_pkg::REG_W-1){1'b0}}, cfg_q.allow_larger};
			default:                 prdata = '0;
		endcase
	end

endmodule

[rtl/mpba_ctrl.sv]
// Controller state machine of the multi-pool block allocator.
// Depends on mpba_pkg for state_t, dp_cmd_t and dp_stat_t.
module mpba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  mpba_pkg::dp_stat_t  stat,
	output logic                in_stall,
	output mpba_pkg::dp_cmd_t   dp_cmd
);

	mpba_pkg::state_t state_q;
	mpba_pkg::state_t state_d;

	assign in_stall = (state_q != mpba_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpba_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mpba_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = mpba_pkg::S_START;
				end
			end
			mpba_pkg::S_START: begin
				if (stat.is_free) begin
					state_d = stat.zero_addr ? mpba_pkg::S_FINISH : mpba_pkg::S_FREE_SCAN;
				end else begin
					state_d = stat.zero_req ? mpba_pkg::S_FINISH : mpba_pkg::S_ALLOC_SCAN;
				end
			end
			mpba_pkg::S_ALLOC_SCAN: begin
				if (stat.elig && (stat.has_free || !stat.allow_larger)) begin
					state_d = mpba_pkg::S_FINISH;
				end else if (stat.last_pool) begin
					state_d = mpba_pkg::S_FINISH;
				end
			end
			mpba_pkg::S_FREE_SCAN: begin
				if (stat.match) begin
					state_d = mpba_pkg::S_DIV;
				end else if (stat.last_pool) begin
					state_d = mpba_pkg::S_FINISH;
				end
			end
			mpba_pkg::S_DIV: begin
				if (stat.div_last) begin
					state_d = mpba_pkg::S_FREE_UPD;
				end
			end
			mpba_pkg::S_FREE_UPD: begin
				state_d = mpba_pkg::S_FINISH;
			end
			mpba_pkg::S_FINISH: begin
				if (stat.out_free) begin
					state_d = mpba_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mpba_pkg::S_IDLE;
			end
		endcase
	end

	// Datapath commands
	always_comb begin
		dp_cmd = '0;
		dp_cmd.st_code = mpba_pkg::ST_OK;
		case (state_q)
			mpba_pkg::S_IDLE: begin
				dp_cmd.load_in = in_valid;
			end
			mpba_pkg::S_START: begin
				if (stat.is_free) begin
					dp_cmd.st_we   = stat.zero_addr;
					dp_cmd.st_code = mpba_pkg::ST_BAD_ADDR;
				end else begin
					dp_cmd.st_we   = stat.zero_req;
					dp_cmd.st_code = mpba_pkg::ST_ZERO_SIZE;
				end
			end
			mpba_pkg::S_ALLOC_SCAN: begin
				if (stat.elig && stat.has_free) begin
					dp_cmd.claim   = 1'b1;
					dp_cmd.st_we   = 1'b1;
					dp_cmd.st_code = mpba_pkg::ST_OK;
				end else if (stat.elig && !stat.allow_larger) begin
					dp_cmd.st_we   = 1'b1;
					dp_cmd.st_code = mpba_pkg::ST_NO_BLOCK;
				end else begin
					dp_cmd.mark_found = stat.elig;
					if (stat.last_pool) begin
						dp_cmd.st_we   = 1'b1;
						dp_cmd.st_code = (stat.found || stat.elig) ?
							mpba_pkg::ST_NO_BLOCK : mpba_pkg::ST_TOO_LARGE;
					end else begin
						dp_cmd.pool_inc = 1'b1;
					end
				end
			end
			mpba_pkg::S_FREE_SCAN: begin
				if (stat.match) begin
					dp_cmd.div_init = 1'b1;
				end else if (stat.last_pool) begin
					dp_cmd.st_we   = 1'b1;
					dp_cmd.st_code = mpba_pkg::ST_BAD_ADDR;
				end else begin
					dp_cmd.pool_inc = 1'b1;
				end
			end
			mpba_pkg::S_DIV: begin
				dp_cmd.div_step = 1'b1;
			end
			mpba_pkg::S_FREE_UPD: begin
				dp_cmd.st_we   = 1'b1;
				dp_cmd.clr_bit = stat.bit_set;
				dp_cmd.st_code = stat.bit_set ? mpba_pkg::ST_OK : mpba_pkg::ST_NOT_USED;
			end
			mpba_pkg::S_FINISH: begin
				dp_cmd.out_load = stat.out_free;
			end
			default: ;
		endcase
	end

endmodule

[rtl/mpba_dp.sv]
// Datapath of the multi-pool block allocator: used bitmaps, pool scan, divider, result.
// Depends on mpba_pkg for the command/status structs, cfg_t and find_first.
module mpba_dp #(
	parameter int unsigned NUM_POOLS  = 4,
	parameter int unsigned MAX_BLOCKS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mpba_pkg::cfg_t                cfg,
	input  mpba_pkg::dp_cmd_t             dp_cmd,
	input  logic                          item_cmd,
	input  logic [mpba_pkg::ADDR_W-1:0]   item_size,
	input  logic [mpba_pkg::ADDR_W-1:0]   item_addr,
	input  logic                          out_stall,
	output mpba_pkg::dp_stat_t            stat,
	output logic                          out_valid,
	output logic [mpba_pkg::ADDR_W-1:0]   block_addr,
	output logic [2:0]                    status
);

	localparam int unsigned PW     = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
	localparam int unsigned IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int unsigned CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned SW     = mpba_pkg::SIZE_W;
	localparam int unsigned AW     = mpba_pkg::ADDR_W;
	localparam int unsigned MW     = mpba_pkg::MAP_W;
	localparam int unsigned DVS_W  = SW + IDX_W;
	localparam int unsigned SPAN_W = SW + CNT_W;

	// Request and scan registers
	logic                  is_free_q;
	logic [AW-1:0]         req_q;
	logic [AW-1:0]         addr_q;
	logic [PW-1:0]         pool_q;
	logic                  found_q;
	logic [AW-1:0]         res_addr_q;
	mpba_pkg::status_t     res_st_q;
	logic [AW-1:0]         rem_q;
	logic [DVS_W-1:0]      dvs_q;
	logic [IDX_W-1:0]      quo_q;
	logic [MAX_BLOCKS-1:0] used_q [NUM_POOLS];
	logic                  out_valid_q;
	logic [AW-1:0]         out_addr_q;
	mpba_pkg::status_t     out_st_q;

	// Per-pool fields
	logic [SW-1:0]         sz_a   [NUM_POOLS];
	logic [SW-1:0]         raw_a  [NUM_POOLS];
	logic [CNT_W-1:0]      cnt_a  [NUM_POOLS];
	logic [AW-1:0]         st_a   [NUM_POOLS];

	logic [SW-1:0]         cur_sz;
	logic [CNT_W-1:0]      cur_cnt;
	logic [AW-1:0]         cur_st;
	logic [MAX_BLOCKS-1:0] cur_used;
	logic [MAX_BLOCKS-1:0] free_vec;
	logic [6:0]            ff;
	logic [IDX_W-1:0]      claim_idx;
	logic [DVS_W-1:0]      claim_off;
	logic [AW-1:0]         claim_addr;
	logic [SPAN_W-1:0]     span;
	logic [AW:0]           pool_end;
	logic                  ge;

	// Unpack the configuration, saturating counts
	always_comb begin
		for (int p = 0; p < NUM_POOLS; p++) begin
			sz_a[p]  = cfg.sizes[SW*p +: SW];
			raw_a[p] = cfg.counts[SW*p +: SW];
			cnt_a[p] = (raw_a[p] > SW'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(raw_a[p]);
			st_a[p]  = (p >= 2) ? cfg.starts_high[AW*(p & 1) +: AW]
			                    : cfg.starts_low[AW*(p & 1) +: AW];
		end
	end

	assign cur_sz   = sz_a[pool_q];
	assign cur_cnt  = cnt_a[pool_q];
	assign cur_st   = st_a[pool_q];
	assign cur_used = used_q[pool_q];

	// Free blocks of the current pool and the lowest one
	always_comb begin
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			free_vec[i] = !cur_used[i] && (CNT_W'(i) < cur_cnt);
		end
	end

	assign ff         = mpba_pkg::find_first(MW'(free_vec));
	assign claim_idx  = IDX_W'(ff[5:0]);
	assign claim_off  = DVS_W'(cur_sz) * DVS_W'(claim_idx);
	assign claim_addr = cur_st + AW'(claim_off);

	// Pool range for a free
	assign span     = SPAN_W'(cur_sz) * SPAN_W'(cur_cnt);
	assign pool_end = {1'b0, cur_st} + (AW+1)'(span);

	// One restoring divide step
	assign ge = (rem_q >= AW'(dvs_q));

	// Status toward the controller
	always_comb begin
		stat.is_free      = is_free_q;
		stat.zero_req     = (req_q == '0);
		stat.zero_addr    = (addr_q == '0);
		stat.allow_larger = cfg.allow_larger;
		stat.elig         = (cur_cnt != '0) && (req_q <= AW'(cur_sz));
		stat.has_free     = ff[6];
		stat.found        = found_q;
		stat.match        = (cur_cnt != '0) && (cur_sz != '0) && (addr_q >= cur_st)
		                    && ({1'b0, addr_q} < pool_end);
		stat.last_pool    = (pool_q == PW'(NUM_POOLS - 1));
		stat.div_last     = (dvs_q == DVS_W'(cur_sz));
		stat.bit_set      = cur_used[quo_q];
		stat.out_free     = !out_valid_q || !out_stall;
	end

	// Latch the request
	always_ff @(posedge clk) begin
		if (dp_cmd.load_in) begin
			is_free_q <= (item_cmd == mpba_pkg::CMD_FREE);
			req_q     <= item_size;
			addr_q    <= item_addr;
		end
	end

	// Pool pointer and spill flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q  <= '0;
			found_q <= 1'b0;
		end else if (dp_cmd.load_in) begin
			pool_q  <= '0;
			found_q <= 1'b0;
		end else begin
			if (dp_cmd.pool_inc) begin
				pool_q <= pool_q + PW'(1);
			end
			if (dp_cmd.mark_found) begin
				found_q <= 1'b1;
			end
		end
	end

	// Result being built
	always_ff @(posedge clk) begin
		if (dp_cmd.load_in) begin
			res_addr_q <= '0;
		end else if (dp_cmd.claim) begin
			res_addr_q <= claim_addr;
		end
		if (dp_cmd.st_we) begin
			res_st_q <= dp_cmd.st_code;
		end
	end

	// Divider: block index of the freed address
	always_ff @(posedge clk) begin
		if (dp_cmd.div_init) begin
			rem_q <= addr_q - cur_st;
			dvs_q <= DVS_W'(cur_sz) << (IDX_W - 1);
			quo_q <= '0;
		end else if (dp_cmd.div_step) begin
			rem_q <= ge ? (rem_q - AW'(dvs_q)) : rem_q;
			dvs_q <= dvs_q >> 1;
			quo_q <= IDX_W'({quo_q, ge});
		end
	end

	// Used bitmaps: set on claim, clear on free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_POOLS; p++) begin
				used_q[p] <= '0;
			end
		end else if (dp_cmd.claim) begin
			used_q[pool_q][claim_idx] <= 1'b1;
		end else if (dp_cmd.clr_bit) begin
			used_q[pool_q][quo_q] <= 1'b0;
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.out_load) begin
			out_addr_q <= res_addr_q;
			out_st_q   <= res_st_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign block_addr = out_addr_q;
	assign status     = out_st_q;

endmodule

[rtl/multi_pool_block_allocator_top.sv]
// Top level of the multi-pool block allocator: config registers, controller, datapath.
// Depends on mpba_pkg, mpba_regs, mpba_ctrl and mpba_dp.
//
//  Channel  Direction  Handshake                  Word
//  input    in         in_valid / in_stall        cmd, req_size, addr
//  output   out        out_valid / out_stall      block_addr, status
//  config   in         psel, penable, pwrite      paddr, pwdata -> prdata, pready
//
// One request at a time. An allocate scans the pools in order, from the first, until
// it can settle the request. A free scans the pools for the one holding the address;
// the block index comes from a restoring divider, one quotient bit per cycle.
// A new request is accepted while the previous result waits in the output register.
// Reset clears all blocks to free and the configuration registers to zero; no clearing pass.
module multi_pool_block_allocator_top #(
	parameter int unsigned NUM_POOLS  = 4,
	parameter int unsigned MAX_BLOCKS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [mpba_pkg::ADDR_W-1:0]   req_size,
	input  logic [mpba_pkg::ADDR_W-1:0]   addr,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mpba_pkg::ADDR_W-1:0]   block_addr,
	output logic [2:0]                    status,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mpba_pkg::PADDR_W-1:0]  paddr,
	input  logic [mpba_pkg::REG_W-1:0]    pwdata,
	output logic [mpba_pkg::REG_W-1:0]    prdata,
	output logic                          pready
);

	mpba_pkg::cfg_t     cfg;
	mpba_pkg::dp_cmd_t  dp_cmd;
	mpba_pkg::dp_stat_t dp_stat;

	mpba_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mpba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (dp_stat),
		.in_stall (in_stall),
		.dp_cmd   (dp_cmd)
	);

	mpba_dp #(
		.NUM_POOLS  (NUM_POOLS),
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.dp_cmd     (dp_cmd),
		.item_cmd   (cmd),
		.item_size  (req_size),
		.item_addr  (addr),
		.out_stall  (out_stall),
		.stat       (dp_stat),
		.out_valid  (out_valid),
		.block_addr (block_addr),
		.status     (status)
	);

`ifndef NO_ASSERTIONS
	// A result is pushed only while a request is in flight
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.out_load |-> in_stall)
		else $error("result loaded with no request in flight");

	// An accepted request blocks the input on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not held after accept");

	// A pushed result shows on the output next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.out_load |=> out_valid)
		else $error("loaded result not presented");
`endif

endmodule
